### src/gf2m_pkg.sv
// Shared types and constants for the GF(2^K) arithmetic unit.
package gf2m_pkg;
    localparam logic [5:0] DEG_RESET = 6'd8;
    localparam logic [31:0] POLY_RESET = 32'd27;
    localparam logic [5:0] MAX_DEGREE = 6'd32;
    localparam logic [0:0] REG_DEGREE = 1'b0;
    localparam logic [0:0] REG_POLY = 1'b1;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_INV = 2'd2;
    localparam logic [1:0] OP_POW = 2'd3;

    typedef enum logic [3:0] {
        t_IDLE, t_MUL, t_PSQ, t_PX, t_INV, t_DONE
    } t_state;
endpackage

### src/gf2m_mulstep.sv
// One bit-serial multiply step: r*X mod p, plus a when the bit of b is set.
module gf2m_mulstep (
    input  logic [31:0] i_r,
    input  logic [31:0] i_a,
    input  logic        i_bit,
    input  logic [31:0] i_mask,
    input  logic [31:0] i_low,
    input  logic [5:0]  i_k,
    output logic [31:0] o_r
);
    logic        w_top;
    logic [31:0] w_x;
    assign w_top = i_r[i_k[4:0] - 5'd1];
    always_comb begin
        w_x = (i_r << 1) & i_mask;
        if (w_top) w_x = w_x ^ i_low;
        o_r = i_bit ? (w_x ^ i_a) : w_x;
    end
endmodule

### src/gf2m_arithmetic_unit_core.sv
// Top level of the GF(2^K) arithmetic unit.
// Usage: raise start with an opcode and operands while busy is low; the
// item is taken at that edge. One result appears on o_result and
// o_zero_operand for one cycle, marked by o_done; it cannot be held off.
// Add goes straight to the done state, from which o_done is registered.
// Multiply shifts operand_b through a shared multiply-step unit one bit per
// cycle. X^n runs 32 square-and-multiply rounds, each a squaring through
// the same step unit plus a times-X step when the exponent bit is set.
// Inverse runs Euclid, one subtract-shift or swap per cycle; every swap
// follows a subtraction and the subtractions lower the summed remainder
// degrees, so the loop ends; the inverse of zero or one takes no step.
// busy stays high through the strobe cycle, so the next item is taken only
// after that cycle; items are handled one at a time.
// Configuration is written by i_cfg_we with an index and data; the user
// must write it only while idle, as the unit leaves this check to the user.
// Reset restores degree 8 and polynomial 0x1B and empties the unit.
module gf2m_arithmetic_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_exponent,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic        o_zero_operand
);
    logic [5:0] r_deg;
    logic [31:0] r_poly;
    gf2m_pkg::t_state r_st, n_st;
    logic [31:0] r_r, n_r, r_a, n_a, r_b, n_b, r_e, n_e;
    logic [32:0] r_r0, n_r0, r_r1, n_r1, r_s0, n_s0, r_s1, n_s1;
    logic [5:0] r_cnt, n_cnt;
    logic [5:0] r_rnd, n_rnd;
    logic r_z, n_z, r_done, n_done;
    logic [5:0] w_k;
    logic [31:0] w_mask, w_low, w_step_r, w_step_a;
    logic [31:0] w_step_r_out;
    logic w_bit;
    logic w_accept;
    logic [5:0] w_d0, w_d1;

    // An item is taken only when the unit is idle and not strobing a result.
    assign w_accept = start && !busy;

    // Saturate the configured degree into the legal range.
    always_comb begin
        w_k = r_deg;
        if (w_k < 6'd2) w_k = 6'd2;
        if (w_k > gf2m_pkg::MAX_DEGREE) w_k = gf2m_pkg::MAX_DEGREE;
    end
    assign w_mask = (w_k == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w_k[4:0]) - 32'd1);
    assign w_low = r_poly & w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= gf2m_pkg::DEG_RESET;
            r_poly <= gf2m_pkg::POLY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gf2m_pkg::REG_DEGREE) r_deg <= i_cfg_data[5:0];
            else r_poly <= i_cfg_data;
        end
    end

    // The shared step shifts r_r and adds r_a when the current multiplier bit is set.
    // For squaring the multiplier is r_b (a frozen copy of r), for power's
    // times-X the addend is dropped and a one-step shift is taken.
    always_comb begin
        w_step_r = r_r;
        w_step_a = r_a;
        w_bit = r_b[r_cnt[4:0]];
        if (r_st == gf2m_pkg::t_PX) w_bit = 1'b0;
    end

    gf2m_mulstep u_step (
        .i_r(w_step_r), .i_a(w_step_a), .i_bit(w_bit), .i_mask(w_mask),
        .i_low(w_low), .i_k(w_k), .o_r(w_step_r_out)
    );

    // Leading-one positions of the Euclid remainders, 33 bits wide.
    function automatic logic [5:0] lead(input logic [32:0] v);
        logic [5:0] d;
        d = 6'd0;
        for (int i = 0; i < 33; i++) if (v[i]) d = 6'(i);
        return d;
    endfunction
    assign w_d0 = lead(r_r0);
    assign w_d1 = lead(r_r1);

    always_comb begin
        n_st = r_st;
        case (r_st)
            gf2m_pkg::t_IDLE:
                if (w_accept) begin
                    case (i_opcode)
                        gf2m_pkg::OP_ADD: n_st = gf2m_pkg::t_DONE;
                        gf2m_pkg::OP_MUL: n_st = gf2m_pkg::t_MUL;
                        gf2m_pkg::OP_INV: n_st = gf2m_pkg::t_INV;
                        default: n_st = gf2m_pkg::t_PSQ;
                    endcase
                end
            gf2m_pkg::t_MUL: if (r_cnt == 6'd0) n_st = gf2m_pkg::t_DONE;
            gf2m_pkg::t_PSQ:
                if (r_cnt == 6'd0) begin
                    if (r_e[31]) n_st = gf2m_pkg::t_PX;
                    else if (r_rnd == 6'd0) n_st = gf2m_pkg::t_DONE;
                end
            gf2m_pkg::t_PX:
                n_st = (r_rnd == 6'd0) ? gf2m_pkg::t_DONE : gf2m_pkg::t_PSQ;
            gf2m_pkg::t_INV: if (r_r1 <= 33'd1) n_st = gf2m_pkg::t_DONE;
            gf2m_pkg::t_DONE: n_st = gf2m_pkg::t_IDLE;
            default: n_st = gf2m_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        n_r = r_r; n_a = r_a; n_b = r_b; n_e = r_e; n_cnt = r_cnt; n_rnd = r_rnd;
        n_r0 = r_r0; n_r1 = r_r1; n_s0 = r_s0; n_s1 = r_s1; n_z = r_z;
        n_done = 1'b0;
        case (r_st)
            gf2m_pkg::t_IDLE:
                if (w_accept) begin
                    n_a = i_operand_a & w_mask;
                    n_b = i_operand_b & w_mask;
                    n_e = i_exponent;
                    n_z = 1'b0;
                    n_cnt = w_k - 6'd1;
                    n_rnd = 6'd31;
                    n_r = (i_opcode == gf2m_pkg::OP_ADD) ?
                          ((i_operand_a ^ i_operand_b) & w_mask) : 32'd0;
                    if (i_opcode == gf2m_pkg::OP_POW) begin
                        n_r = 32'd0; n_a = 32'd1; n_b = 32'd1;
                    end
                    n_r0 = ({1'b0, w_low}) | (33'd1 << w_k);
                    n_r1 = {1'b0, i_operand_a & w_mask};
                    n_s0 = 33'd0;
                    n_s1 = 33'd1;
                    if (i_opcode == gf2m_pkg::OP_INV && (i_operand_a & w_mask) == 32'd0)
                        n_z = 1'b1;
                end
            gf2m_pkg::t_MUL: begin
                n_r = w_step_r_out;
                n_cnt = r_cnt - 6'd1;
            end
            gf2m_pkg::t_PSQ: begin
                n_r = w_step_r_out;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_a = w_step_r_out; n_b = w_step_r_out;
                    n_cnt = w_k - 6'd1;
                    if (!r_e[31]) begin
                        n_r = 32'd0;
                        n_e = r_e << 1;
                        n_rnd = r_rnd - 6'd1;
                        if (r_rnd == 6'd0) n_r = w_step_r_out;
                    end
                end
            end
            gf2m_pkg::t_PX: begin
                n_a = w_step_r_out; n_b = w_step_r_out;
                n_r = (r_rnd == 6'd0) ? w_step_r_out : 32'd0;
                n_e = r_e << 1;
                n_rnd = r_rnd - 6'd1;
                n_cnt = w_k - 6'd1;
            end
            gf2m_pkg::t_INV:
                if (r_r1 > 33'd1) begin
                    if (w_d0 >= w_d1) begin
                        n_r0 = r_r0 ^ (r_r1 << (w_d0 - w_d1));
                        n_s0 = r_s0 ^ (r_s1 << (w_d0 - w_d1));
                    end else begin
                        n_r0 = r_r1; n_r1 = r_r0; n_s0 = r_s1; n_s1 = r_s0;
                    end
                end else begin
                    n_r = r_z ? 32'd0 : (r_s1[31:0] & w_mask);
                end
            gf2m_pkg::t_DONE: n_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= gf2m_pkg::t_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= n_done;
        end
        r_r <= n_r; r_a <= n_a; r_b <= n_b; r_e <= n_e; r_cnt <= n_cnt;
        r_rnd <= n_rnd; r_r0 <= n_r0; r_r1 <= n_r1; r_s0 <= n_s0; r_s1 <= n_s1;
        r_z <= n_z;
    end

    assign busy = (r_st != gf2m_pkg::t_IDLE) || r_done;
    assign o_done = r_done;
    assign o_result = r_r;
    assign o_zero_operand = r_z;
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the GF(2^K) arithmetic unit core.
module tb_top;
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] exponent;
    } t_gf_req;

    typedef struct packed {
        logic [31:0] result;
        logic        zero_operand;
    } t_gf_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic [31:0] i_exponent;
    logic        o_done;
    logic [31:0] o_result;
    logic        o_zero_operand;

    gf2m_arithmetic_unit_core dut (.*);

    // The predictor keeps its own copy of the two configuration registers.
    logic [5:0]  model_degree;
    logic [31:0] model_poly;

    t_gf_req pending_items[$];
    t_gf_res expected_results[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      sender_hold;
    int      gap_left;
    int      burst_left;
    int      pause_items;

    // Generous limit on the whole run: the slowest item is a power at K=32.
    localparam longint CYCLE_LIMIT = 64'd4_000_000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_degree(input logic [5:0] deg);
        if (deg < 2) begin
            return 2;
        end
        if (deg > gf2m_pkg::MAX_DEGREE) begin
            return gf2m_pkg::MAX_DEGREE;
        end
        return deg;
    endfunction

    function automatic logic [63:0] field_mask(input int k);
        return (64'd1 << k) - 64'd1;
    endfunction

    function automatic logic [63:0] shift_x(input logic [63:0] r, input int k,
                                             input logic [63:0] low);
        logic top;
        top = r[k-1];
        r = (r << 1) & field_mask(k);
        if (top) begin
            r = r ^ low;
        end
        return r;
    endfunction

    function automatic logic [63:0] field_mul(input logic [63:0] a, input logic [63:0] b,
                                               input int k, input logic [63:0] low);
        logic [63:0] r;
        r = '0;
        for (int i = k - 1; i >= 0; i--) begin
            r = shift_x(r, k, low);
            if (b[i]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    function automatic int top_bit(input logic [63:0] v);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                d = i;
            end
        end
        return d;
    endfunction

    // Extended Euclid over the full minimal polynomial. With a reducible
    // polynomial it stops at remainder 0 or 1 and keeps that cofactor.
    function automatic logic [63:0] field_inv(input logic [63:0] a, input int k,
                                               input logic [63:0] low);
        logic [63:0] r0, r1, s0, s1, t;
        int d;
        r0 = (64'd1 << k) | low;
        r1 = a;
        s0 = '0;
        s1 = 64'd1;
        while (r1 > 1) begin
            while (r1 != 0 && top_bit(r0) >= top_bit(r1)) begin
                d = top_bit(r0) - top_bit(r1);
                r0 = r0 ^ (r1 << d);
                s0 = s0 ^ (s1 << d);
            end
            t = r0; r0 = r1; r1 = t;
            t = s0; s0 = s1; s1 = t;
        end
        return s1 & field_mask(k);
    endfunction

    function automatic t_gf_res predict_result(input t_gf_req req);
        t_gf_res res;
        logic [63:0] m, low, a, b, r;
        int k;
        k = eff_degree(model_degree);
        m = field_mask(k);
        low = {32'd0, model_poly} & m;
        a = {32'd0, req.operand_a} & m;
        b = {32'd0, req.operand_b} & m;
        res.zero_operand = 1'b0;
        r = '0;
        case (req.opcode)
            gf2m_pkg::OP_ADD: begin
                r = a ^ b;
            end
            gf2m_pkg::OP_MUL: begin
                r = field_mul(a, b, k, low);
            end
            gf2m_pkg::OP_INV: begin
                if (a == 0) begin
                    res.zero_operand = 1'b1;
                end else begin
                    r = field_inv(a, k, low);
                end
            end
            default: begin
                r = 64'd1;
                for (int i = 31; i >= 0; i--) begin
                    r = field_mul(r, r, k, low);
                    if (req.exponent[i]) begin
                        r = shift_x(r, k, low);
                    end
                end
            end
        endcase
        res.result = r[31:0] & m[31:0];
        return res;
    endfunction

    // Driver: takes items from the pending queue in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_opcode <= gf2m_pkg::OP_ADD;
            i_operand_a <= '0;
            i_operand_b <= '0;
            i_exponent <= '0;
        end else begin
            if (start && !busy) begin
                expected_results = {expected_results, predict_result(
                    {i_opcode, i_operand_a, i_operand_b, i_exponent})};
            end
            if (start && busy) begin
                // Item still waiting for acceptance; keep it on the ports.
            end else if (sender_hold || pending_items.size() == 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                t_gf_req req;
                req = pending_items.pop_front();
                start <= 1'b1;
                i_opcode <= req.opcode;
                i_operand_a <= req.operand_a;
                i_operand_b <= req.operand_b;
                i_exponent <= req.exponent;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(8, 0);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end
        end
    end

    // Monitor: every strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h zero %b", $time, o_result,
                         o_zero_operand);
                error_count++;
            end else begin
                t_gf_res exp_res;
                exp_res = expected_results.pop_front();
                if (exp_res.result !== o_result) begin
                    $display("%0t: result expected %h actual %h", $time,
                             exp_res.result, o_result);
                    error_count++;
                end
                if (exp_res.zero_operand !== o_zero_operand) begin
                    $display("%0t: zero flag expected %b actual %b", $time,
                             exp_res.zero_operand, o_zero_operand);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1 << $urandom_range(31, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] n);
        t_gf_req req;
        req.opcode = op;
        req.operand_a = a;
        req.operand_b = b;
        req.exponent = n;
        pending_items = {pending_items, req};
    endtask

    // Waits until every item is taken and its result checked. Sampling on
    // the falling edge sees the settled state of the driver and monitor.
    task automatic drain_unit();
        @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // One register write, driven between rising edges.
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gf2m_pkg::REG_DEGREE) begin
            model_degree = data[5:0];
        end else begin
            model_poly = data;
        end
    endtask

    initial begin
        logic [5:0]  deg_list[8];
        logic [31:0] poly_list[8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sender_hold = 1'b0;
        gap_left = 0;
        burst_left = 0;
        model_degree = gf2m_pkg::DEG_RESET;
        model_poly = gf2m_pkg::POLY_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items in the reset field GF(2^8): extremes, every
        // operation, inverse of zero and of one, and wide operands.
        queue_item(gf2m_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF);
        queue_item(gf2m_pkg::OP_ADD, 32'd0, 32'd0, 32'd0);
        queue_item(gf2m_pkg::OP_MUL, 32'h53, 32'hCA, 32'd0);
        queue_item(gf2m_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(gf2m_pkg::OP_MUL, 32'd0, 32'hFF, 32'd0);
        queue_item(gf2m_pkg::OP_INV, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(gf2m_pkg::OP_INV, 32'hFFFF_FF00, 32'd0, 32'd0);
        queue_item(gf2m_pkg::OP_INV, 32'd1, 32'd0, 32'd0);
        queue_item(gf2m_pkg::OP_INV, 32'h53, 32'd0, 32'd0);
        queue_item(gf2m_pkg::OP_INV, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_item(gf2m_pkg::OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        queue_item(gf2m_pkg::OP_POW, 32'd0, 32'd0, 32'd1);
        queue_item(gf2m_pkg::OP_POW, 32'd0, 32'd0, 32'd255);
        queue_item(gf2m_pkg::OP_POW, 32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_item(gf2m_pkg::OP_POW, 32'd0, 32'd0, 32'h8000_0000);
        drain_unit();

        // Field settings: extremes of the degree (including values that
        // saturate), reducible and irreducible polynomials, wide bits.
        deg_list = '{6'd0, 6'd2, 6'd32, 6'd63, 6'd5, 6'd16, 6'd8, 6'd31};
        poly_list = '{32'd3, 32'd7, 32'h0040_0007, 32'hFFFF_FFFF,
                      32'h5, 32'h100B, 32'h0, 32'h8000_0009};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(gf2m_pkg::REG_DEGREE, {26'd0, deg_list[ph]});
            write_reg(gf2m_pkg::REG_POLY, poly_list[ph]);
            for (int i = 0; i < 110; i++) begin
                queue_item(2'($urandom_range(3, 0)), rand_word(), rand_word(), rand_word());
            end
            // Once per run, hold the sender until every result has come.
            if (ph == 3) begin
                pause_items = pending_items.size();
                while (pending_items.size() > pause_items / 2) @(negedge i_clk);
                sender_hold = 1'b1;
                @(negedge i_clk);
                while (start || expected_results.size() != 0) @(negedge i_clk);
                repeat ($urandom_range(20, 1)) @(negedge i_clk);
                sender_hold = 1'b0;
            end
            drain_unit();
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
